>>> rtl/core/owrse_pkg.sv
// Shared types and constants for the 1-Wire ROM search engine.
// No dependencies; used by every module under rtl/core.
package owrse_pkg;

   localparam int unsigned ROM_BITS    = 64;
   localparam int unsigned POS_W       = 7;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] CMD_NORMAL = 8'hF0;
   localparam logic [7:0] CMD_COND   = 8'hEC;
   localparam logic [POS_W-1:0] LAST_BIT = POS_W'(ROM_BITS);

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_TARGET = 2'd1,
      ACT_START  = 2'd2,
      ACT_BITS   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_COMMAND   = 2'd0,
      KIND_DIRECTION = 2'd1,
      KIND_FINISHED  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [7:0]             command_byte;
      logic                   direction_bit;
      logic                   found;
      logic [ROM_BITS-1:0]    found_code;
      logic                   last_device;
      logic                   last;
   } result_type;

   localparam result_type RESULT_NONE = '{
      kind: KIND_COMMAND, command_byte: 8'h00, direction_bit: 1'b0, found: 1'b0,
      found_code: '0, last_device: 1'b0, last: 1'b0
   };

   // Results handed from the decision logic to the result queue.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

>>> rtl/core/onewire_rom_search_engine_unit.sv
// 1-Wire ROM search decision engine, top level.
// Depends on owrse_pkg, owrse_decide and owrse_rspq.
//
// Takes one request per clock while req_ready is high: clear the search,
// target a family, start a pass (presence and normal/conditional mode), or
// one bit pair read from the bus. The branch decision and the search state
// update are made in the cycle the request is accepted; its results (none,
// one, or two after bit 64) are registered in a result queue of QUEUE_DEPTH
// entries and leave on the rsp port in order, one per cycle while rsp_ready
// is high. req_ready is high while the queue has at least two free entries,
// so with a ready consumer a request is taken every cycle; the output port,
// one result per cycle, sets the sustained rate for two-result requests.
// Pass finished results carry the code and last-device flag only when found.
module onewire_rom_search_engine_unit #(
   parameter int unsigned QUEUE_DEPTH = owrse_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_family,
   input  logic        req_presence,
   input  logic        req_conditional,
   input  logic        req_id_bit,
   input  logic        req_comp_bit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_command_byte,
   output logic        rsp_direction_bit,
   output logic        rsp_found,
   output logic [63:0] rsp_found_code,
   output logic        rsp_last_device,
   output logic        rsp_last
);

   logic                  accept;
   owrse_pkg::push_type   push;
   owrse_pkg::result_type head;

   // request is consumed when queue has room for its worst case
   assign accept = req_valid && req_ready;

   owrse_decide u_decide (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_action),
      .family      (req_family),
      .presence    (req_presence),
      .conditional (req_conditional),
      .id_bit      (req_id_bit),
      .comp_bit    (req_comp_bit),
      .push        (push)
   );

   owrse_rspq #(
      .DEPTH (QUEUE_DEPTH)
   ) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept),
      .push      (push),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_kind          = head.kind;
   assign rsp_command_byte  = head.command_byte;
   assign rsp_direction_bit = head.direction_bit;
   assign rsp_found         = head.found;
   assign rsp_found_code    = head.found_code;
   assign rsp_last_device   = head.last_device;
   assign rsp_last          = head.last;

endmodule

>>> rtl/core/owrse_decide.sv
// Search state registers and the per-request branch decision.
// Depends on owrse_pkg.
module owrse_decide (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [1:0]                  action,
   input  logic [7:0]                  family,
   input  logic                        presence,
   input  logic                        conditional,
   input  logic                        id_bit,
   input  logic                        comp_bit,
   output owrse_pkg::push_type         push
);

   localparam int unsigned PW = owrse_pkg::POS_W;

   logic [owrse_pkg::ROM_BITS-1:0] rom_ff, rom_in;
   logic [PW-1:0] ld_ff, ld_in;
   logic          ldf_ff, ldf_in;
   logic [PW-1:0] bp_ff, bp_in;
   logic [PW-1:0] lz_ff, lz_in;
   logic          active_ff, active_in;

   owrse_pkg::push_type  res;
   logic [5:0]           idx;
   logic                 dir;
   logic [PW-1:0]        lz_new;
   logic [owrse_pkg::ROM_BITS-1:0] rom_new;

   always_comb begin
      rom_in    = rom_ff;
      ld_in     = ld_ff;
      ldf_in    = ldf_ff;
      bp_in     = bp_ff;
      lz_in     = lz_ff;
      active_in = active_ff;
      res.count  = 2'd0;
      res.first  = owrse_pkg::RESULT_NONE;
      res.second = owrse_pkg::RESULT_NONE;
      idx     = 6'(bp_ff - PW'(1));
      lz_new  = lz_ff;
      dir     = id_bit;
      if (id_bit == comp_bit) begin
         if (bp_ff < ld_ff) dir = rom_ff[idx];
         else               dir = (bp_ff == ld_ff);
         if (!dir) lz_new = bp_ff;
      end
      rom_new      = rom_ff;
      rom_new[idx] = dir;

      case (owrse_pkg::action_type'(action))
         owrse_pkg::ACT_CLEAR: begin
            rom_in    = '0;
            ld_in     = '0;
            ldf_in    = 1'b0;
            active_in = 1'b0;
            bp_in     = '0;
            lz_in     = '0;
         end
         owrse_pkg::ACT_TARGET: begin
            rom_in    = {{(owrse_pkg::ROM_BITS-8){1'b0}}, family};
            ld_in     = owrse_pkg::LAST_BIT;
            ldf_in    = 1'b0;
            active_in = 1'b0;
            bp_in     = '0;
            lz_in     = '0;
         end
         owrse_pkg::ACT_START: begin
            res.count      = 2'd1;
            res.first.last = 1'b1;
            if (ldf_ff || !presence) begin
               ld_in     = '0;
               ldf_in    = 1'b0;
               active_in = 1'b0;
               bp_in     = '0;
               lz_in     = '0;
               res.first.kind = owrse_pkg::KIND_FINISHED;
            end else begin
               active_in = 1'b1;
               bp_in     = PW'(1);
               lz_in     = '0;
               res.first.kind         = owrse_pkg::KIND_COMMAND;
               res.first.command_byte = conditional ? owrse_pkg::CMD_COND
                                                    : owrse_pkg::CMD_NORMAL;
            end
         end
         owrse_pkg::ACT_BITS: begin
            if (active_ff && bp_ff >= PW'(1) && bp_ff <= owrse_pkg::LAST_BIT) begin
               if (id_bit && comp_bit) begin
                  // no device answered: abort as not found
                  ld_in     = '0;
                  ldf_in    = 1'b0;
                  active_in = 1'b0;
                  bp_in     = '0;
                  lz_in     = '0;
                  res.count      = 2'd1;
                  res.first.kind = owrse_pkg::KIND_FINISHED;
                  res.first.last = 1'b1;
               end else begin
                  rom_in = rom_new;
                  res.first.kind          = owrse_pkg::KIND_DIRECTION;
                  res.first.direction_bit = dir;
                  if (bp_ff < owrse_pkg::LAST_BIT) begin
                     bp_in          = bp_ff + PW'(1);
                     lz_in          = lz_new;
                     res.count      = 2'd1;
                     res.first.last = 1'b1;
                  end else begin
                     active_in = 1'b0;
                     bp_in     = '0;
                     lz_in     = '0;
                     res.count       = 2'd2;
                     res.second.kind = owrse_pkg::KIND_FINISHED;
                     res.second.last = 1'b1;
                     if (rom_new[7:0] == 8'h00) begin
                        ld_in  = '0;
                        ldf_in = 1'b0;
                     end else begin
                        ld_in  = lz_new;
                        ldf_in = (lz_new == '0);
                        res.second.found       = 1'b1;
                        res.second.found_code  = rom_new;
                        res.second.last_device = (lz_new == '0);
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff    <= '0;
         ld_ff     <= '0;
         ldf_ff    <= 1'b0;
         bp_ff     <= '0;
         lz_ff     <= '0;
         active_ff <= 1'b0;
      end else if (accept) begin
         rom_ff    <= rom_in;
         ld_ff     <= ld_in;
         ldf_ff    <= ldf_in;
         bp_ff     <= bp_in;
         lz_ff     <= lz_in;
         active_ff <= active_in;
      end
   end

   assign push = res;

endmodule

>>> rtl/core/owrse_rspq.sv
// Result queue: up to two results in per cycle, one out if ready.
// Depends on owrse_pkg.
module owrse_rspq #(
   parameter int unsigned DEPTH = owrse_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_en,
   input  owrse_pkg::push_type   push,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output owrse_pkg::result_type out_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   owrse_pkg::result_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    n_push;
   logic          pop;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign n_push    = push_en ? push.count : 2'd0;
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= CW'(DEPTH - 2));
   assign out_data  = mem_ff[rd_ff];
   assign wr_next   = wrap_inc(wr_ff);

   always_comb begin
      wr_in = wr_ff;
      if (n_push == 2'd1) wr_in = wr_next;
      else if (n_push == 2'd2) wr_in = wrap_inc(wr_next);
      rd_in    = pop ? wrap_inc(rd_ff) : rd_ff;
      count_in = count_ff + CW'(n_push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) mem_ff[wr_ff] <= push.first;
      if (n_push == 2'd2) mem_ff[wr_next] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
